// ===== rtl/mosaic_tile_average_assert.svh =====
// Assertion macros used by the mosaic tile average back end.
`ifndef MOSAIC_TILE_AVERAGE_ASSERT_SVH
`define MOSAIC_TILE_AVERAGE_ASSERT_SVH
// Same-cycle implication under synchronous active-low reset.
`define MTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mosaic tile average: assertion failed");
// Next-cycle implication under synchronous active-low reset.
`define MTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mosaic tile average: assertion failed");
`endif

// ===== rtl/mta_pkg.sv =====
// Types, constants and helpers of the mosaic tile average block.
`default_nettype none
package mta_pkg;
    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MAX_TILE       = 64;
    localparam int TILE_MAP_DEPTH = 16384;
    localparam int COL_AW         = $clog2(MAX_WIDTH);
    localparam int MAP_AW         = $clog2(TILE_MAP_DEPTH);
    localparam int SUM_W          = 20;
    localparam int COL_W          = 3 * SUM_W;
    localparam int DIV_STEPS      = 20;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TILE_SIZE    = 2'd2;

    localparam logic [1:0] OP_PUSH       = 2'd0;
    localparam logic [1:0] OP_PUSH_FIRST = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    localparam logic KIND_TILE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_UNF = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [12:0] w;
        logic [12:0] h;
        logic [6:0]  ts;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic        oof;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] qr;
        logic [11:0] qc;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req item;
    } t_qif;

    typedef struct packed {
        logic        kind;
        logic [11:0] tile_row;
        logic [11:0] tile_col;
        logic [7:0]  avg_red;
        logic [7:0]  avg_green;
        logic [7:0]  avg_blue;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [12:0]      den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [12:0] clamp13(input logic [12:0] v, input logic [12:0] hi);
        logic [12:0] r;
        if (v == 13'd0) r = 13'd1;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mta_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/mta_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module mta_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mta_pkg::t_div_req i_req,
    output mta_pkg::t_div_rsp o_rsp
);
    import mta_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [12:0]          r_rem;
    logic [12:0]          r_den;
    logic [SUM_W-1:0]     r_num;
    logic [13:0]          rem_sh;
    logic [13:0]          diff;
    logic                 ge;

    assign rem_sh = {r_rem, r_num[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_num  <= i_req.num;
            end else if (r_busy) begin
                r_rem <= ge ? diff[12:0] : rem_sh[12:0];
                r_num <= {r_num[SUM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule
`default_nettype wire

// ===== rtl/mta_front.sv =====
// Front end: classify incoming requests and hold them in a short queue.
`default_nettype none
module mta_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mta_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  logic          i_command,
    input  logic          i_first_of_frame,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [11:0]   i_query_row,
    input  logic [11:0]   i_query_col,
    input  logic          i_clearing,
    input  logic          i_take,
    output logic          o_full,
    output mta_pkg::t_qif o_q
);
    import mta_pkg::*;

    t_req       r_slot [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    t_req       cls;
    logic       wr;

    // classify: push, push opening a frame, or query (flag positions outside the frame)
    always_comb begin
        cls.op    = i_command ? OP_QUERY : (i_first_of_frame ? OP_PUSH_FIRST : OP_PUSH);
        cls.oof   = ({1'b0, i_query_row} >= i_cfg.h) || ({1'b0, i_query_col} >= i_cfg.w);
        cls.red   = i_red;
        cls.green = i_green;
        cls.blue  = i_blue;
        cls.qr    = i_query_row;
        cls.qc    = i_query_col;
    end

    assign o_full = (r_count == 2'(QUEUE_DEPTH)) || i_clearing;
    assign wr     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_slot[r_wp] <= cls;
                r_wp         <= r_wp + 1'b1;
            end
            if (i_take) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + 2'(wr) - 2'(i_take);
        end
    end

    assign o_q.valid = r_count != 2'd0;
    assign o_q.item  = r_slot[r_rp];
endmodule
`default_nettype wire

// ===== rtl/mta_back.sv =====
// Back end: sequencer for tile accumulation, averaging and tile map queries.
`default_nettype none
`include "mosaic_tile_average_assert.svh"
module mta_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mta_pkg::t_cfg i_cfg,
    input  mta_pkg::t_qif i_q,
    output logic          o_take,
    output logic          o_clearing,
    output mta_pkg::t_res o_res,
    output logic          o_res_valid,
    input  logic          i_res_pop
);
    import mta_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_CHK  = 5'd2,  S_DIVR = 5'd3;
    localparam logic [4:0] S_DIVC = 5'd4,  S_MUL  = 5'd5,  S_LAST = 5'd6,  S_ACC  = 5'd7;
    localparam logic [4:0] S_SRD  = 5'd8,  S_SADD = 5'd9,  S_CNT  = 5'd10, S_DTPR = 5'd11;
    localparam logic [4:0] S_IDX  = 5'd12, S_QIDX = 5'd13, S_DRED = 5'd14, S_DGRN = 5'd15;
    localparam logic [4:0] S_DBLU = 5'd16, S_QP1  = 5'd17, S_QP2  = 5'd18, S_QCMP = 5'd19;
    localparam logic [4:0] S_QRD  = 5'd20, S_QDAT = 5'd21, S_EMIT = 5'd22;

    logic [4:0]        r_state, n_state;
    t_req              r_item;
    logic [11:0]       r_raster_row, r_raster_col;
    logic              r_frame_over;
    logic [14:0]       r_tiles_done;
    logic [11:0]       r_pos_row, r_pos_col;
    logic [11:0]       r_tr, r_tc, r_r0, r_c0, r_last_r, r_last_c, r_sc;
    logic [12:0]       r_tpr, r_cnt;
    logic [24:0]       r_idx, r_last_pos, r_cur_pos;
    logic [SUM_W-1:0]  r_sum_r, r_sum_g, r_sum_b;
    logic [23:0]       r_rgb;
    logic [1:0]        r_status;
    logic [COL_AW-1:0] r_clr;
    logic              r_out_valid;
    t_res              r_out;

    logic              is_push, skip, finish, ovf, q_done;
    logic [18:0]       r0_full, c0_full;
    logic [12:0]       end_r, end_c, lim_r, lim_c, cnt_c;
    logic [6:0]        h_cnt, w_cnt;
    logic [24:0]       idx_c, last_pos_c, cur_pos_c;
    logic [SUM_W-1:0]  sl_r, sl_g, sl_b, base_r, base_g, base_b;
    logic              col_we, map_we;
    logic [COL_AW-1:0] col_wr_addr, col_rd_addr;
    logic [COL_W-1:0]  col_wr_data, col_rd;
    logic [23:0]       map_rd;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign is_push = r_item.op != OP_QUERY;
    assign skip    = r_frame_over || ({1'b0, r_raster_row} >= i_cfg.h)
                     || ({1'b0, r_raster_col} >= i_cfg.w);
    assign r0_full = 19'(r_tr) * 19'(i_cfg.ts);
    assign c0_full = 19'(r_tc) * 19'(i_cfg.ts);
    assign end_r   = 13'(r_r0) + 13'(i_cfg.ts);
    assign end_c   = 13'(r_c0) + 13'(i_cfg.ts);
    assign lim_r   = (end_r < i_cfg.h) ? end_r : i_cfg.h;
    assign lim_c   = (end_c < i_cfg.w) ? end_c : i_cfg.w;
    assign finish  = (r_pos_row == r_last_r) && (r_pos_col == r_last_c);
    assign h_cnt   = 7'(r_pos_row - r_r0) + 7'd1;
    assign w_cnt   = 7'(r_pos_col - r_c0) + 7'd1;
    assign cnt_c   = 13'(h_cnt) * 13'(w_cnt);
    assign idx_c   = 25'(r_tr) * 25'(r_tpr) + 25'(r_tc);
    assign ovf     = r_idx >= 25'(TILE_MAP_DEPTH);
    assign last_pos_c = 25'(r_last_r) * 25'(i_cfg.w) + 25'(r_last_c);
    assign cur_pos_c  = 25'(r_raster_row) * 25'(i_cfg.w) + 25'(r_raster_col);
    assign q_done  = r_frame_over || (r_last_pos < r_cur_pos);

    assign sl_r   = col_rd[3*SUM_W-1:2*SUM_W];
    assign sl_g   = col_rd[2*SUM_W-1:SUM_W];
    assign sl_b   = col_rd[SUM_W-1:0];
    // first row of a tile band starts the column sums afresh
    assign base_r = (r_pos_row == r_r0) ? '0 : sl_r;
    assign base_g = (r_pos_row == r_r0) ? '0 : sl_g;
    assign base_b = (r_pos_row == r_r0) ? '0 : sl_b;

    always_comb begin
        n_state     = r_state;
        o_take      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = 13'(i_cfg.ts);
        unique case (r_state)
            S_IDLE: if (i_q.valid) begin
                o_take  = 1'b1;
                n_state = S_CHK;
            end
            S_CLR: if (r_clr == COL_AW'(MAX_WIDTH - 1)) n_state = S_IDLE;
            S_CHK: begin
                if (is_push && skip) begin
                    n_state = S_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = SUM_W'(is_push ? r_raster_row : r_item.qr);
                    n_state       = S_DIVR;
                end
            end
            S_DIVR: if (div_rsp.done) begin
                div_req.start = 1'b1;
                div_req.num   = SUM_W'(r_pos_col);
                n_state       = S_DIVC;
            end
            S_DIVC: if (div_rsp.done) begin
                if (is_push) begin
                    n_state = S_MUL;
                end else if (r_item.oof) begin
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = SUM_W'(i_cfg.w) + SUM_W'(i_cfg.ts) - SUM_W'(1);
                    n_state       = S_DTPR;
                end
            end
            S_MUL:  n_state = S_LAST;
            S_LAST: n_state = is_push ? S_ACC : S_QP1;
            S_ACC:  n_state = finish ? S_SRD : S_IDLE;
            S_SRD:  n_state = S_SADD;
            S_SADD: n_state = (r_sc == r_pos_col) ? S_CNT : S_SRD;
            S_CNT: begin
                div_req.start = 1'b1;
                div_req.num   = SUM_W'(i_cfg.w) + SUM_W'(i_cfg.ts) - SUM_W'(1);
                n_state       = S_DTPR;
            end
            S_DTPR: if (div_rsp.done) n_state = S_IDX;
            S_IDX: begin
                if (is_push) begin
                    div_req.start = 1'b1;
                    div_req.num   = r_sum_r;
                    div_req.den   = r_cnt;
                    n_state       = S_DRED;
                end else begin
                    n_state = S_QIDX;
                end
            end
            S_QIDX: n_state = ovf ? S_EMIT : S_MUL;
            S_DRED: if (div_rsp.done) begin
                div_req.start = 1'b1;
                div_req.num   = r_sum_g;
                div_req.den   = r_cnt;
                n_state       = S_DGRN;
            end
            S_DGRN: if (div_rsp.done) begin
                div_req.start = 1'b1;
                div_req.num   = r_sum_b;
                div_req.den   = r_cnt;
                n_state       = S_DBLU;
            end
            S_DBLU: if (div_rsp.done) n_state = S_EMIT;
            S_QP1:  n_state = S_QP2;
            S_QP2:  n_state = S_QCMP;
            S_QCMP: n_state = q_done ? S_QRD : S_EMIT;
            S_QRD:  n_state = S_QDAT;
            S_QDAT: n_state = S_EMIT;
            S_EMIT: if (!r_out_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        col_we      = (r_state == S_ACC) || (r_state == S_CLR);
        col_wr_addr = (r_state == S_CLR) ? r_clr : COL_AW'(r_pos_col);
        col_wr_data = (r_state == S_CLR) ? '0
                    : {base_r + SUM_W'(r_item.red), base_g + SUM_W'(r_item.green),
                       base_b + SUM_W'(r_item.blue)};
        col_rd_addr = (r_state == S_SRD) ? COL_AW'(r_sc) : COL_AW'(r_pos_col);
        map_we      = (r_state == S_EMIT) && !r_out_valid && is_push && (r_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_raster_row <= '0;
            r_raster_col <= '0;
            r_frame_over <= 1'b0;
            r_tiles_done <= '0;
        end else begin
            r_state <= n_state;
            if (i_res_pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_q.valid) begin
                    r_item <= i_q.item;
                    if (i_q.item.op == OP_PUSH_FIRST) begin
                        r_raster_row <= '0;
                        r_raster_col <= '0;
                        r_frame_over <= 1'b0;
                        r_tiles_done <= '0;
                    end
                end
                S_CLR: r_clr <= r_clr + 1'b1;
                S_CHK: begin
                    r_pos_row <= is_push ? r_raster_row : r_item.qr;
                    r_pos_col <= is_push ? r_raster_col : r_item.qc;
                end
                S_DIVR: if (div_rsp.done) r_tr <= div_rsp.quot[11:0];
                S_DIVC: if (div_rsp.done) begin
                    r_tc <= div_rsp.quot[11:0];
                    if (!is_push && r_item.oof) begin
                        r_status <= ST_UNF;
                        r_rgb    <= '0;
                    end
                end
                S_MUL: begin
                    r_r0 <= r0_full[11:0];
                    r_c0 <= c0_full[11:0];
                end
                S_LAST: begin
                    r_last_r <= 12'(lim_r - 13'd1);
                    r_last_c <= 12'(lim_c - 13'd1);
                end
                S_ACC: begin
                    // advance the raster position
                    if ({1'b0, r_pos_col} + 13'd1 < i_cfg.w) begin
                        r_raster_col <= r_pos_col + 12'd1;
                    end else begin
                        r_raster_col <= '0;
                        if ({1'b0, r_pos_row} + 13'd1 < i_cfg.h) r_raster_row <= r_pos_row + 12'd1;
                        else r_frame_over <= 1'b1;
                    end
                    r_sum_r <= '0;
                    r_sum_g <= '0;
                    r_sum_b <= '0;
                    r_sc    <= r_c0;
                end
                S_SADD: begin
                    r_sum_r <= r_sum_r + sl_r;
                    r_sum_g <= r_sum_g + sl_g;
                    r_sum_b <= r_sum_b + sl_b;
                    r_sc    <= r_sc + 12'd1;
                end
                S_CNT:  r_cnt <= cnt_c;
                S_DTPR: if (div_rsp.done) r_tpr <= div_rsp.quot[12:0];
                S_IDX:  r_idx <= idx_c;
                S_QIDX: if (ovf) begin
                    r_status <= ST_OVF;
                    r_rgb    <= '0;
                end
                S_DRED: if (div_rsp.done) r_rgb[23:16] <= div_rsp.quot[7:0];
                S_DGRN: if (div_rsp.done) r_rgb[15:8] <= div_rsp.quot[7:0];
                S_DBLU: if (div_rsp.done) begin
                    r_rgb[7:0] <= div_rsp.quot[7:0];
                    r_status   <= ovf ? ST_OVF : ST_OK;
                end
                S_QP1: r_last_pos <= last_pos_c;
                S_QP2: r_cur_pos  <= cur_pos_c;
                S_QCMP: if (!q_done) begin
                    r_status <= ST_UNF;
                    r_rgb    <= '0;
                end
                S_QDAT: begin
                    r_rgb    <= map_rd;
                    r_status <= ST_OK;
                end
                S_EMIT: if (!r_out_valid) begin
                    r_out_valid     <= 1'b1;
                    r_out.kind      <= is_push ? KIND_TILE : KIND_QUERY;
                    r_out.tile_row  <= r_tr;
                    r_out.tile_col  <= r_tc;
                    r_out.avg_red   <= r_rgb[23:16];
                    r_out.avg_green <= r_rgb[15:8];
                    r_out.avg_blue  <= r_rgb[7:0];
                    r_out.status    <= r_status;
                    if (is_push && r_tiles_done != 15'h7FFF) r_tiles_done <= r_tiles_done + 15'd1;
                end
                default: ;
            endcase
        end
    end

    mta_ram #(.WIDTH(COL_W), .DEPTH(MAX_WIDTH)) u_col_ram (
        .i_clk     (i_clk),
        .i_we      (col_we),
        .i_wr_addr (col_wr_addr),
        .i_wr_data (col_wr_data),
        .i_rd_addr (col_rd_addr),
        .o_rd_data (col_rd)
    );

    mta_ram #(.WIDTH(24), .DEPTH(TILE_MAP_DEPTH)) u_map_ram (
        .i_clk     (i_clk),
        .i_we      (map_we),
        .i_wr_addr (MAP_AW'(r_idx)),
        .i_wr_data (r_rgb),
        .i_rd_addr (MAP_AW'(r_idx)),
        .o_rd_data (map_rd)
    );

    mta_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_clearing  = r_state == S_CLR;
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    `MTA_ASSERT_IMP(a_no_take_in_clear, i_clk, i_rst_n, r_state == S_CLR, !o_take)
    `MTA_ASSERT_NXT(a_emit_loads_out, i_clk, i_rst_n, r_state == S_EMIT && !r_out_valid, r_out_valid)
    `MTA_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
endmodule
`default_nettype wire

// ===== rtl/mosaic_tile_average.sv =====
// Top level of the mosaic tile average block.
// The back end works on one request at a time; all of its divisions share one divider.
// A two-entry request queue and a result register let each side stall on its own.
// Reset (synchronous, active low): registers return to 640 x 480, tile 8; raster cleared.
// After reset a clearing pass zeroes all 4096 column sums while full stays high.
`default_nettype none
module mosaic_tile_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic        i_first_of_frame,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_query_row,
    input  logic [11:0] i_query_col,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [11:0] o_tile_row,
    output logic [11:0] o_tile_col,
    output logic [7:0]  o_avg_red,
    output logic [7:0]  o_avg_green,
    output logic [7:0]  o_avg_blue,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);
    import mta_pkg::*;

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [6:0]  r_tile_size;
    t_cfg        cfg;
    t_qif        q;
    t_res        res;
    logic        take;
    logic        clearing;
    logic        res_valid;
    logic [12:0] ts_wide;

    // hold the configuration; writes outside the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_tile_size    <= 7'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_TILE_SIZE:    r_tile_size    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clamp the registers into their working ranges
    assign ts_wide = clamp13({6'd0, r_tile_size}, 13'(MAX_TILE));
    assign cfg.w   = clamp13(r_frame_width, 13'(MAX_WIDTH));
    assign cfg.h   = clamp13(r_frame_height, 13'(MAX_HEIGHT));
    assign cfg.ts  = ts_wide[6:0];

    mta_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_push           (push),
        .i_command        (i_command),
        .i_first_of_frame (i_first_of_frame),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_query_row      (i_query_row),
        .i_query_col      (i_query_col),
        .i_clearing       (clearing),
        .i_take           (take),
        .o_full           (full),
        .o_q              (q)
    );

    mta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q         (q),
        .o_take      (take),
        .o_clearing  (clearing),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    // present the waiting result held in the result register
    assign empty       = !res_valid;
    assign o_kind      = res.kind;
    assign o_tile_row  = res.tile_row;
    assign o_tile_col  = res.tile_col;
    assign o_avg_red   = res.avg_red;
    assign o_avg_green = res.avg_green;
    assign o_avg_blue  = res.avg_blue;
    assign o_status    = res.status;
endmodule
`default_nettype wire

// ===== dv/mosaic_tile_average_checker.sv =====
// Checker for the mosaic tile average block: predicts tile averages and query answers.
`timescale 1ns / 100ps
module mosaic_tile_average_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_command,
    input  logic        i_first_of_frame,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_query_row,
    input  logic [11:0] i_query_col,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_kind,
    input  logic [11:0] i_tile_row,
    input  logic [11:0] i_tile_col,
    input  logic [7:0]  i_avg_red,
    input  logic [7:0]  i_avg_green,
    input  logic [7:0]  i_avg_blue,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    import mta_pkg::*;

    logic [12:0] width_reg, height_reg;
    logic [6:0]  tile_reg;
    int unsigned cur_row, cur_col;
    bit          frame_done;
    logic [19:0] band_red [MAX_WIDTH];
    logic [19:0] band_green [MAX_WIDTH];
    logic [19:0] band_blue [MAX_WIDTH];
    logic [23:0] tile_colours [TILE_MAP_DEPTH];
    t_res        awaited [$];
    int          errors;

    assign o_pending = awaited.size();
    assign o_errors  = errors;

    function automatic int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic post(logic k, int unsigned tr, int unsigned tc, logic [23:0] rgb,
                        logic [1:0] st);
        t_res r;
        r.kind      = k;
        r.tile_row  = tr[11:0];
        r.tile_col  = tc[11:0];
        r.avg_red   = rgb[23:16];
        r.avg_green = rgb[15:8];
        r.avg_blue  = rgb[7:0];
        r.status    = st;
        awaited.push_back(r);
    endtask

    task automatic take_request();
        int unsigned w, h, ts, per_row, rr, rc, tr, tc, r0, c0, lr, lc, sr, sg, sb, cnt, c;
        int unsigned idx;
        longint unsigned last_pos, cur_pos;
        logic [23:0] rgb;
        w  = limit(width_reg, 1, MAX_WIDTH);
        h  = limit(height_reg, 1, MAX_HEIGHT);
        ts = limit(tile_reg, 1, MAX_TILE);
        per_row = (w + ts - 1) / ts;
        if (!i_command) begin
            if (i_first_of_frame) begin
                cur_row = 0;
                cur_col = 0;
                frame_done = 0;
            end
            rr = cur_row;
            rc = cur_col;
            if (frame_done || rr >= h || rc >= w) return;
            tr = rr / ts;
            tc = rc / ts;
            r0 = tr * ts;
            c0 = tc * ts;
            if (rr == r0) begin
                band_red[rc] = '0;
                band_green[rc] = '0;
                band_blue[rc] = '0;
            end
            band_red[rc]   += i_red;
            band_green[rc] += i_green;
            band_blue[rc]  += i_blue;
            lr = (r0 + ts < h ? r0 + ts : h) - 1;
            lc = (c0 + ts < w ? c0 + ts : w) - 1;
            if (rc + 1 < w) cur_col = rc + 1;
            else begin
                cur_col = 0;
                if (rr + 1 < h) cur_row = rr + 1;
                else frame_done = 1;
            end
            if (rr == lr && rc == lc) begin
                sr = 0; sg = 0; sb = 0;
                for (c = c0; c <= rc; c++) begin
                    sr += band_red[c];
                    sg += band_green[c];
                    sb += band_blue[c];
                end
                cnt = (rr - r0 + 1) * (rc - c0 + 1);
                rgb = {8'(sr / cnt), 8'(sg / cnt), 8'(sb / cnt)};
                idx = tr * per_row + tc;
                if (idx < TILE_MAP_DEPTH) begin
                    tile_colours[idx] = rgb;
                    post(KIND_TILE, tr, tc, rgb, ST_OK);
                end else begin
                    post(KIND_TILE, tr, tc, rgb, ST_OVF);
                end
            end
        end else begin
            tr = i_query_row / ts;
            tc = i_query_col / ts;
            if (i_query_row >= h || i_query_col >= w) begin
                post(KIND_QUERY, tr, tc, '0, ST_UNF);
                return;
            end
            idx = tr * per_row + tc;
            if (idx >= TILE_MAP_DEPTH) begin
                post(KIND_QUERY, tr, tc, '0, ST_OVF);
                return;
            end
            r0 = tr * ts;
            c0 = tc * ts;
            lr = (r0 + ts < h ? r0 + ts : h) - 1;
            lc = (c0 + ts < w ? c0 + ts : w) - 1;
            last_pos = longint'(lr) * w + lc;
            cur_pos  = longint'(cur_row) * w + cur_col;
            if (frame_done || last_pos < cur_pos)
                post(KIND_QUERY, tr, tc, tile_colours[idx], ST_OK);
            else
                post(KIND_QUERY, tr, tc, '0, ST_UNF);
        end
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            tile_reg   <= 7'd8;
            cur_row    = 0;
            cur_col    = 0;
            frame_done = 0;
            errors     = 0;
            awaited.delete();
            for (int i = 0; i < MAX_WIDTH; i++) begin
                band_red[i] = '0; band_green[i] = '0; band_blue[i] = '0;
            end
            for (int i = 0; i < TILE_MAP_DEPTH; i++) tile_colours[i] = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  width_reg  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg <= i_cfg_data;
                    CFG_TILE_SIZE:    tile_reg   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) take_request();
            if (i_pop && !i_empty) begin
                got = '{i_kind, i_tile_row, i_tile_col, i_avg_red, i_avg_green, i_avg_blue,
                        i_status};
                if (awaited.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/mosaic_tile_average_tb.sv =====
// Testbench top of the mosaic tile average block: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module mosaic_tile_average_tb;
    import mta_pkg::*;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   SETTLE    = 300;        // longest tile close with 64-wide tiles, plus margin
    localparam int   LIMIT     = 2_000_000;
    localparam int   N_ITEMS   = 1300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full, empty;
    logic        pop = 1'b0;
    logic        i_command = CMD_PUSH;
    logic        i_first_of_frame = 1'b0;
    logic [7:0]  i_red = '0, i_green = '0, i_blue = '0;
    logic [11:0] i_query_row = '0, i_query_col = '0;
    logic        o_kind;
    logic [11:0] o_tile_row, o_tile_col;
    logic [7:0]  o_avg_red, o_avg_green, o_avg_blue;
    logic [1:0]  o_status;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;
    int          pending, failures;
    int          cycles = 0;
    int          sent = 0;
    bit          quiet = 0;       // no idling on either side
    bit          long_hold = 0;   // ask the receiver for one long hold-off

    mosaic_tile_average DUT (.*);

    mosaic_tile_average_checker checker_i (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_command, .i_first_of_frame,
        .i_red, .i_green, .i_blue, .i_query_row, .i_query_col,
        .i_empty(empty), .i_pop(pop), .i_kind(o_kind), .i_tile_row(o_tile_row),
        .i_tile_col(o_tile_col), .i_avg_red(o_avg_red), .i_avg_green(o_avg_green),
        .i_avg_blue(o_avg_blue), .i_status(o_status), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_errors(failures)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run; the budget covers the clearing pass and every stall.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("mosaic_tile_average_tb: FAIL");
            $finish;
        end
    end

    // Result side: pop freely, with random hold-off bursts and one long hold-off.
    initial begin
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                pop <= 1'b0;
                long_hold = 0;
                repeat (400) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Offer one request and hold it until it is taken. Call at a falling edge.
    task automatic offer(logic cmd, logic fof, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                         logic [11:0] qr, logic [11:0] qc);
        bit taken;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_first_of_frame <= fof;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        i_query_row <= qr;
        i_query_col <= qc;
        // full only moves at a rising edge, so its value here holds up to the next one
        do begin
            taken = !full;
            @(negedge i_clk);
        end while (!taken);
        sent++;
    endtask

    task automatic pixel(logic fof);
        offer(CMD_PUSH, fof, 8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom),
              12'($urandom));
    endtask

    task automatic query(int unsigned row, int unsigned col);
        offer(CMD_QUERY, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), row[11:0],
              col[11:0]);
    endtask

    // Drop push, drain every awaited result and let the back end go quiet.
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One write cycle, then the enable goes low again before the task returns.
    task automatic write_reg(logic [1:0] idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[12:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned ts);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_TILE_SIZE, ts);
    endtask

    initial begin
        int unsigned w, h, ts, n_pix, done_pix, budget, phase;
        bit held;
        held = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry: nothing finished yet, and a position off the frame.
        query(0, 0);
        query(4095, 4095);
        settle();

        // 3 x 2 frame with 2-pixel tiles: one full tile, one clipped at the right edge.
        set_frame(3, 2, 2);
        offer(CMD_PUSH, 1'b1, 8'hFF, 8'hFF, 8'hFF, '0, '0);
        offer(CMD_PUSH, 1'b0, 8'h00, 8'h00, 8'h00, '0, '0);
        query(0, 2);                                   // tile not yet finished
        offer(CMD_PUSH, 1'b0, 8'hFF, 8'h00, 8'hFF, '0, '0);
        offer(CMD_PUSH, 1'b0, 8'hFF, 8'hFF, 8'hFF, '0, '0);
        offer(CMD_PUSH, 1'b0, 8'hFF, 8'hFF, 8'h00, '0, '0);
        offer(CMD_PUSH, 1'b0, 8'h00, 8'hFF, 8'hFF, '0, '0);
        offer(CMD_PUSH, 1'b0, 8'h12, 8'h34, 8'h56, '0, '0); // past the frame end: ignored
        query(1, 1);
        query(0, 2);
        offer(CMD_QUERY, 1'b1, '0, '0, '0, 12'd1, 12'd3); // off the frame, first flag ignored
        settle();

        // Out-of-range register values clamp: one column, 4096 rows, 1-pixel tiles.
        set_frame(0, 8191, 0);
        pixel(1'b1);
        repeat (4) pixel(1'b0);
        query(4095, 0);
        settle();
        // Widen mid-frame: row 5 now maps past the end of the tile map.
        write_reg(CFG_FRAME_WIDTH, 8191);
        pixel(1'b0);
        pixel(1'b0);
        query(5, 0);
        settle();

        // Widest frame with the largest tile, clamped from 127.
        set_frame(4096, 1, 127);
        pixel(1'b1);
        repeat (69) pixel(1'b0);
        query(0, 65);
        query(0, 10);
        settle();

        // Random frames: mostly well-formed raster runs with queries mixed in.
        phase = 0;
        while (sent < N_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(64, 4096);
                h = $urandom_range(1, 2);
                ts = $urandom_range(16, 64);
            end else begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 16);
                ts = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            end
            set_frame(w, h, ts);
            n_pix = w * h + $urandom_range(0, 2);
            if (n_pix > 200) n_pix = 200;
            budget = n_pix + n_pix / 3 + 2;
            // hold the receiver off once over a frame long enough to fill the block
            if (!held && phase >= 2 && n_pix >= 40) begin
                long_hold = 1;
                held = 1;
            end
            if (sent > N_ITEMS - 150) quiet = 1;
            pixel(1'b1);
            done_pix = 1;
            while (budget > 0) begin
                budget--;
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        query($urandom_range(0, 4095), $urandom_range(0, 4095));
                    else
                        query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
                end else if (done_pix < n_pix) begin
                    // rarely restart the raster part way through
                    pixel($urandom_range(0, 49) == 0);
                    done_pix++;
                end
            end
            settle();
            phase++;
        end

        quiet = 1;
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("mosaic_tile_average_tb: PASS");
        end else begin
            $display("mosaic_tile_average_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== mosaic_tile_average.f =====
+incdir+rtl
rtl/mta_pkg.sv
rtl/mta_ram.sv
rtl/mta_divider.sv
rtl/mta_front.sv
rtl/mta_back.sv
rtl/mosaic_tile_average.sv
dv/mosaic_tile_average_checker.sv
dv/mosaic_tile_average_tb.sv
